// File: src/btat_pkg.sv
`timescale 1ns / 1ps

package btat_pkg;

    localparam int MAX_TRACKS = 64;
    localparam int COORD_BITS = 12;
    localparam int IDX_W      = $clog2(MAX_TRACKS);
    localparam int CNT_W      = $clog2(MAX_TRACKS + 1);
    localparam int CFG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int OP_W       = 2;
    localparam int SQ_W       = 2 * COORD_BITS;
    localparam int SUM_W      = SQ_W + 1;
    localparam int GATE_W     = 2 * CFG_W;
    localparam int TDATA_IN_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int TDATA_OUT_W = ((IDX_W + 2 + 2 * CNT_W + 7) / 8) * 8;

    localparam logic [CFG_W-1:0] IDLE_MAX           = 7'd127;
    localparam logic [CFG_W-1:0] MATCH_DIST_RESET   = 7'd25;
    localparam logic [CFG_W-1:0] IDLE_LIMIT_RESET   = 7'd10;

    localparam logic [OP_W-1:0] OP_DETECT = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_DISTANCE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_LIMIT     = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic             ended;
        logic [CFG_W-1:0] idle;
        coord_t           y;
        coord_t           x;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            count_zero;
        logic            issue_done;
        logic            hit;
        logic            scan_last;
        logic            tick_last;
    } status_t;

endpackage

// File: src/btat_ram.sv
`timescale 1ns / 1ps

module btat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/btat_ctrl.sv
`timescale 1ns / 1ps

module btat_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  btat_pkg::status_t st,
    output btat_pkg::cmd_t    cmd
);

    import btat_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_TICK   = 3'd3;
    localparam logic [2:0] S_COMMIT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.load   = s_tvalid && (state_reg == S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                case (st.op)
                    OP_DETECT: state_next = st.count_zero ? S_COMMIT : S_SCAN;
                    OP_TICK:   state_next = st.count_zero ? S_COMMIT : S_TICK;
                    default:   state_next = S_COMMIT;
                endcase
            end
            S_SCAN:
            begin
                cmd.rd_en = !st.issue_done;
                // first hit out of the pipe is the lowest-indexed match
                if (st.hit || st.scan_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_TICK:
            begin
                cmd.rd_en = !st.issue_done;
                if (st.tick_last)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid_next = cmd.commit ? 1'b1 : (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/btat_dp.sv
`timescale 1ns / 1ps

module btat_dp (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic [btat_pkg::OP_W-1:0]             op,
    input  logic [btat_pkg::TDATA_IN_W-1:0]       s_tdata,
    input  logic                                  cfg_we,
    input  logic [btat_pkg::CFG_IDX_W-1:0]        cfg_idx,
    input  logic [btat_pkg::CFG_W-1:0]            cfg_wdata,
    input  btat_pkg::cmd_t                        cmd,
    output btat_pkg::status_t                     st,
    output logic [btat_pkg::TDATA_OUT_W-1:0]      m_tdata
);

    import btat_pkg::*;

    // configuration
    logic [CFG_W-1:0]  match_distance_reg;
    logic [CFG_W-1:0]  idle_limit_reg;
    logic [GATE_W-1:0] gate_reg;

    // latched item
    logic [OP_W-1:0] op_reg;
    coord_t          x_reg;
    coord_t          y_reg;

    // table state
    logic [CNT_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             issue_done_reg;
    logic             rd_last;

    // read pipeline
    logic             s1_v_reg;
    logic             s1_last_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s2_v_reg;
    logic             s2_last_reg;
    logic             s2_ended_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [SQ_W-1:0]  sqx_reg;
    logic [SQ_W-1:0]  sqy_reg;
    logic             found_reg;
    logic [IDX_W-1:0] found_idx_reg;
    logic [CNT_W-1:0] ended_cnt_reg;

    // memory port
    entry_t           rd_entry;
    logic [ENTRY_W-1:0] rdata;
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wentry;

    // scan datapath
    coord_t           dx, dy;
    logic [SQ_W-1:0]  sqx_next, sqy_next;
    logic [SUM_W-1:0] dist_sum;
    logic             in_gate;
    logic             s2_hit;
    logic             is_tick;

    // tick datapath
    logic [CFG_W-1:0] idle_inc;
    logic             end_now;
    logic             tick_wr;

    // result
    logic [IDX_W-1:0] out_idx_reg, out_idx_next;
    logic             out_created_reg, out_created_next;
    logic             out_dropped_reg, out_dropped_next;
    logic [CNT_W-1:0] out_total_reg;
    logic [CNT_W-1:0] out_ended_reg, out_ended_next;
    logic             commit_wr;
    logic             full;

    assign rd_entry = entry_t'(rdata);
    assign is_tick  = (op_reg == OP_TICK);
    assign full     = (count_reg == CNT_W'(MAX_TRACKS));
    assign rd_last  = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == count_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_distance_reg <= MATCH_DIST_RESET;
            idle_limit_reg     <= IDLE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_MATCH_DISTANCE: match_distance_reg <= cfg_wdata;
                CFG_IDLE_LIMIT:     idle_limit_reg     <= cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        gate_reg <= GATE_W'(match_distance_reg) * GATE_W'(match_distance_reg);
    end

    // scan stage 1: distance squares from the entry just read
    always_comb
    begin
        dx       = (x_reg > rd_entry.x) ? (x_reg - rd_entry.x) : (rd_entry.x - x_reg);
        dy       = (y_reg > rd_entry.y) ? (y_reg - rd_entry.y) : (rd_entry.y - y_reg);
        sqx_next = SQ_W'(dx) * SQ_W'(dx);
        sqy_next = SQ_W'(dy) * SQ_W'(dy);
    end

    // scan stage 2: gate compare
    assign dist_sum = SUM_W'(sqx_reg) + SUM_W'(sqy_reg);
    assign in_gate  = (dist_sum < SUM_W'(gate_reg));
    assign s2_hit   = s2_v_reg && in_gate && !s2_ended_reg && !found_reg;

    // tick: age the entry read last cycle and write it straight back
    always_comb
    begin
        idle_inc = (rd_entry.idle < IDLE_MAX) ? (rd_entry.idle + CFG_W'(1)) : rd_entry.idle;
        end_now  = (idle_inc == idle_limit_reg) && !rd_entry.ended;
        tick_wr  = s1_v_reg && is_tick;
    end

    always_comb
    begin
        count_next       = count_reg;
        out_idx_next     = '0;
        out_created_next = 1'b0;
        out_dropped_next = 1'b0;
        out_ended_next   = '0;
        commit_wr        = 1'b0;
        waddr            = s1_idx_reg;
        wentry.ended     = rd_entry.ended || end_now;
        wentry.idle      = idle_inc;
        wentry.y         = rd_entry.y;
        wentry.x         = rd_entry.x;
        if (cmd.commit)
        begin
            case (op_reg)
                OP_DETECT:
                begin
                    wentry.ended = 1'b0;
                    wentry.idle  = '0;
                    wentry.y     = y_reg;
                    wentry.x     = x_reg;
                    if (found_reg)
                    begin
                        commit_wr    = 1'b1;
                        waddr        = found_idx_reg;
                        out_idx_next = found_idx_reg;
                    end
                    else if (!full)
                    begin
                        commit_wr        = 1'b1;
                        waddr            = count_reg[IDX_W-1:0];
                        out_idx_next     = count_reg[IDX_W-1:0];
                        out_created_next = 1'b1;
                        count_next       = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        out_dropped_next = 1'b1;
                    end
                end
                OP_TICK:
                begin
                    out_ended_next = ended_cnt_reg;
                end
                OP_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign we = tick_wr || commit_wr;

    btat_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_TRACKS)
    ) u_table (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (rd_idx_reg),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b0;
            s1_v_reg       <= 1'b0;
            s2_v_reg       <= 1'b0;
            found_reg      <= 1'b0;
            ended_cnt_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cmd.load)
            begin
                rd_idx_reg     <= '0;
                issue_done_reg <= 1'b0;
                s1_v_reg       <= 1'b0;
                s2_v_reg       <= 1'b0;
                found_reg      <= 1'b0;
                ended_cnt_reg  <= '0;
            end
            else
            begin
                s1_v_reg <= cmd.rd_en;
                s2_v_reg <= s1_v_reg && !is_tick;
                if (cmd.rd_en)
                begin
                    rd_idx_reg <= rd_idx_reg + IDX_W'(1);
                    if (rd_last)
                    begin
                        issue_done_reg <= 1'b1;
                    end
                end
                if (s2_hit)
                begin
                    found_reg <= 1'b1;
                end
                if (tick_wr && end_now)
                begin
                    ended_cnt_reg <= ended_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= op;
            x_reg  <= s_tdata[COORD_BITS-1:0];
            y_reg  <= s_tdata[2*COORD_BITS-1:COORD_BITS];
        end
        s1_idx_reg   <= rd_idx_reg;
        s1_last_reg  <= rd_last;
        s2_idx_reg   <= s1_idx_reg;
        s2_last_reg  <= s1_last_reg;
        s2_ended_reg <= rd_entry.ended;
        sqx_reg      <= sqx_next;
        sqy_reg      <= sqy_next;
        if (s2_hit)
        begin
            found_idx_reg <= s2_idx_reg;
        end
        if (cmd.commit)
        begin
            out_idx_reg     <= out_idx_next;
            out_created_reg <= out_created_next;
            out_dropped_reg <= out_dropped_next;
            out_total_reg   <= count_next;
            out_ended_reg   <= out_ended_next;
        end
    end

    always_comb
    begin
        st.op         = op_reg;
        st.count_zero = (count_reg == '0);
        st.issue_done = issue_done_reg;
        st.hit        = s2_hit;
        st.scan_last  = s2_v_reg && s2_last_reg;
        st.tick_last  = tick_wr && s1_last_reg;
    end

    assign m_tdata = TDATA_OUT_W'({out_ended_reg, out_total_reg, out_dropped_reg,
                                   out_created_reg, out_idx_reg});

endmodule

// File: src/blob_track_association_table.sv
`timescale 1ns / 1ps

// Track association table for up to 64 object tracks. Each stream item on the
// input carries an operation in s_tuser: a detection is matched against the
// stored tracks in index order, one track per cycle through the single read
// port of the track memory; a frame tick reads, ages and writes back one
// track per cycle; clear and the unused code read no tracks. One item is
// worked on at a time and every item gives exactly one result on the output
// side; the next item is taken once the block is back in idle, even while a
// result waits. Gate radius and idle limit must be written on the cfg port
// while idle; the user is bound to this, the block itself does not enforce it.

module blob_track_association_table (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: pos_x [11:0], pos_y [23:12]
    input  logic [btat_pkg::TDATA_IN_W-1:0]      s_tdata,
    // s_tuser: op [1:0]
    input  logic [btat_pkg::OP_W-1:0]            s_tuser,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // m_tdata: track_index [5:0], created [6], dropped [7], tracks_total [14:8],
    //          ended_now [21:15], zero fill [23:22]
    output logic [btat_pkg::TDATA_OUT_W-1:0]     m_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic                                 cfg_we,
    input  logic [btat_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  logic [btat_pkg::CFG_W-1:0]           cfg_wdata
);

    import btat_pkg::*;

    cmd_t    cmd;
    status_t st;

    btat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .st       (st),
        .cmd      (cmd)
    );

    btat_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .st        (st),
        .m_tdata   (m_tdata)
    );

endmodule
